// ===== rtl/krnr_pkg.sv =====
// Shared codes and types for the KKT residual norm reducer.
// No dependencies; used by every module under rtl/.
package krnr_pkg;

    localparam logic [1:0] CMD_EQ    = 2'd0;
    localparam logic [1:0] CMD_INEQ  = 2'd1;
    localparam logic [1:0] CMD_COORD = 2'd2;

    localparam int BP_LOWER = 0;
    localparam int BP_UPPER = 1;

    // per-word control carried down the pipeline
    typedef struct packed {
        logic nonfinite;
        logic last;
        logic meas;
    } t_flags;

endpackage

// ===== rtl/krnr_prep.sv =====
// Term formation stage: magnitudes, differences, violation candidates and
// multiplier operands for one word. Depends on krnr_pkg.
module krnr_prep #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  logic [1:0]                  i_command,
    input  logic [VALUE_WIDTH-1:0]      i_row_residual,
    input  logic [VALUE_WIDTH-1:0]      i_row_multiplier,
    input  logic [VALUE_WIDTH-1:0]      i_x_value,
    input  logic [VALUE_WIDTH-1:0]      i_z_value,
    input  logic [VALUE_WIDTH-1:0]      i_grad_value,
    input  logic [VALUE_WIDTH-1:0]      i_lower_bound,
    input  logic [VALUE_WIDTH-1:0]      i_upper_bound,
    input  logic [1:0]                  i_bound_present,
    input  logic                        i_excluded,
    input  logic                        i_nonfinite,
    input  logic                        i_last,
    output logic                        o_valid,
    output krnr_pkg::t_flags            o_flags,
    output logic [VALUE_WIDTH-2:0]      o_eq,
    output logic [VALUE_WIDTH-2:0]      o_v0,
    output logic [VALUE_WIDTH-2:0]      o_v1,
    output logic [VALUE_WIDTH-2:0]      o_stat,
    output logic [VALUE_WIDTH-1:0]      o_pa,
    output logic [VALUE_WIDTH-1:0]      o_pb
);
    localparam int W = VALUE_WIDTH;

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] a);
        logic [W-1:0] na;
        na = -a;
        return a[W-1] ? na : a;
    endfunction

    function automatic logic [W-2:0] f_sat(input logic [W-1:0] u);
        return u[W-1] ? {(W-1){1'b1}} : u[W-2:0];
    endfunction

    // magnitude of a W+1 bit signed difference, always fits W bits
    function automatic logic [W-1:0] f_absd(input logic [W:0] d);
        logic [W:0] nd;
        nd = -d;
        return d[W] ? nd[W-1:0] : d[W-1:0];
    endfunction

    function automatic logic [W-1:0] f_posd(input logic [W:0] d);
        return d[W] ? '0 : d[W-1:0];
    endfunction

    logic [W:0]   d_lo;
    logic [W:0]   d_up;
    logic [W:0]   d_gz;
    logic         lo_on;
    logic         up_on;
    logic         z_neg;
    logic         meas;

    logic [W-2:0] n_eq, n_v0, n_v1, n_stat;
    logic [W-1:0] n_pa, n_pb;

    logic                r_valid;
    krnr_pkg::t_flags    r_flags;
    logic [W-2:0]        r_eq, r_v0, r_v1, r_stat;
    logic [W-1:0]        r_pa, r_pb;

    assign d_lo  = {i_lower_bound[W-1], i_lower_bound} - {i_x_value[W-1], i_x_value};
    assign d_up  = {i_x_value[W-1], i_x_value} - {i_upper_bound[W-1], i_upper_bound};
    assign d_gz  = {i_grad_value[W-1], i_grad_value} - {i_z_value[W-1], i_z_value};
    assign lo_on = i_bound_present[krnr_pkg::BP_LOWER];
    assign up_on = i_bound_present[krnr_pkg::BP_UPPER];
    assign z_neg = i_z_value[W-1];
    assign meas  = (i_command == krnr_pkg::CMD_COORD) && !i_excluded;

    always_comb begin
        n_eq   = '0;
        n_v0   = '0;
        n_v1   = '0;
        n_stat = '0;
        n_pa   = '0;
        n_pb   = '0;
        unique case (i_command)
            krnr_pkg::CMD_EQ: begin
                n_eq = f_sat(f_mag(i_row_residual));
            end
            krnr_pkg::CMD_INEQ: begin
                if (!i_row_residual[W-1]) begin
                    n_v0 = i_row_residual[W-2:0];
                end
                n_pa = f_mag(i_row_multiplier);
                n_pb = f_mag(i_row_residual);
            end
            krnr_pkg::CMD_COORD: begin
                if (!i_excluded) begin
                    n_stat = f_sat(f_absd(d_gz));
                end
                if (lo_on) begin
                    n_v0 = f_sat(f_posd(d_lo));
                end
                if (up_on) begin
                    n_v1 = f_sat(f_posd(d_up));
                end
                // the two bound prices are exclusive on the sign of z
                if (lo_on && !z_neg) begin
                    n_pa = i_z_value;
                    n_pb = f_absd(d_lo);
                end else if (up_on && z_neg) begin
                    n_pa = f_mag(i_z_value);
                    n_pb = f_absd(d_up);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_flags.nonfinite <= i_nonfinite;
            r_flags.last      <= i_last;
            r_flags.meas      <= meas;
            r_eq              <= n_eq;
            r_v0              <= n_v0;
            r_v1              <= n_v1;
            r_stat            <= n_stat;
            r_pa              <= n_pa;
            r_pb              <= n_pb;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_eq    = r_eq;
    assign o_v0    = r_v0;
    assign o_v1    = r_v1;
    assign o_stat  = r_stat;
    assign o_pa    = r_pa;
    assign o_pb    = r_pb;

endmodule

// ===== rtl/krnr_mul.sv =====
// Product stage: complementarity product and merge of the two violation
// candidates. Depends on krnr_pkg.
module krnr_mul #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  krnr_pkg::t_flags            i_flags,
    input  logic [VALUE_WIDTH-2:0]      i_eq,
    input  logic [VALUE_WIDTH-2:0]      i_v0,
    input  logic [VALUE_WIDTH-2:0]      i_v1,
    input  logic [VALUE_WIDTH-2:0]      i_stat,
    input  logic [VALUE_WIDTH-1:0]      i_pa,
    input  logic [VALUE_WIDTH-1:0]      i_pb,
    output logic                        o_valid,
    output krnr_pkg::t_flags            o_flags,
    output logic [VALUE_WIDTH-2:0]      o_eq,
    output logic [VALUE_WIDTH-2:0]      o_viol,
    output logic [VALUE_WIDTH-2:0]      o_stat,
    output logic [2*VALUE_WIDTH-1:0]    o_prod
);
    localparam int W = VALUE_WIDTH;

    logic [2*W-1:0]      n_prod;
    logic [W-2:0]        n_viol;

    logic                r_valid;
    krnr_pkg::t_flags    r_flags;
    logic [W-2:0]        r_eq, r_viol, r_stat;
    logic [2*W-1:0]      r_prod;

    assign n_prod = {{W{1'b0}}, i_pa} * {{W{1'b0}}, i_pb};
    assign n_viol = (i_v1 > i_v0) ? i_v1 : i_v0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_flags <= i_flags;
            r_eq    <= i_eq;
            r_viol  <= n_viol;
            r_stat  <= i_stat;
            r_prod  <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_eq    = r_eq;
    assign o_viol  = r_viol;
    assign o_stat  = r_stat;
    assign o_prod  = r_prod;

endmodule

// ===== rtl/krnr_accum.sv =====
// Running maxima and result register; clears the maxima on the last word.
// Depends on krnr_pkg.
module krnr_accum #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  krnr_pkg::t_flags            i_flags,
    input  logic [VALUE_WIDTH-2:0]      i_eq,
    input  logic [VALUE_WIDTH-2:0]      i_viol,
    input  logic [VALUE_WIDTH-2:0]      i_stat,
    input  logic [2*VALUE_WIDTH-1:0]    i_prod,
    input  logic                        i_out_stall,
    output logic                        o_blocked,
    output logic                        o_out_valid,
    output logic [VALUE_WIDTH-2:0]      o_feasibility_eq,
    output logic [VALUE_WIDTH-2:0]      o_feasibility_ineq,
    output logic [VALUE_WIDTH-2:0]      o_stationarity,
    output logic [VALUE_WIDTH-2:0]      o_complementarity,
    output logic                        o_stationarity_valid,
    output logic                        o_measured
);
    localparam int W = VALUE_WIDTH;

    logic [2*W-1:0] shifted;
    logic [W-2:0]   comp;
    logic           take;

    logic [W-2:0]   n_max_eq, n_max_viol, n_max_stat, n_max_comp;
    logic           n_any, n_seen;

    logic [W-2:0]   r_max_eq, r_max_viol, r_max_stat, r_max_comp;
    logic           r_any, r_seen;

    logic           r_out_valid;
    logic [W-2:0]   r_out_eq, r_out_ineq, r_out_stat, r_out_comp;
    logic           r_out_stat_valid, r_out_measured;

    // truncate the Q product, then clamp to the largest positive value
    assign shifted = i_prod >> FRACTION_BITS;
    assign comp    = (shifted[2*W-1:W-1] != '0) ? {(W-1){1'b1}} : shifted[W-2:0];
    assign take    = i_adv && i_valid;

    assign n_max_eq   = (i_eq   > r_max_eq)   ? i_eq   : r_max_eq;
    assign n_max_viol = (i_viol > r_max_viol) ? i_viol : r_max_viol;
    assign n_max_stat = (i_stat > r_max_stat) ? i_stat : r_max_stat;
    assign n_max_comp = (comp   > r_max_comp) ? comp   : r_max_comp;
    assign n_any      = r_any  | i_flags.meas;
    assign n_seen     = r_seen | i_flags.nonfinite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_eq    <= '0;
            r_max_viol  <= '0;
            r_max_stat  <= '0;
            r_max_comp  <= '0;
            r_any       <= 1'b0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take && i_flags.last) begin
                r_max_eq    <= '0;
                r_max_viol  <= '0;
                r_max_stat  <= '0;
                r_max_comp  <= '0;
                r_any       <= 1'b0;
                r_seen      <= 1'b0;
                r_out_valid <= 1'b1;
            end else begin
                if (take) begin
                    r_max_eq   <= n_max_eq;
                    r_max_viol <= n_max_viol;
                    r_max_stat <= n_max_stat;
                    r_max_comp <= n_max_comp;
                    r_any      <= n_any;
                    r_seen     <= n_seen;
                end
                if (!i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
        if (take && i_flags.last) begin
            r_out_eq         <= n_seen ? '0 : n_max_eq;
            r_out_ineq       <= n_seen ? '0 : n_max_viol;
            r_out_stat       <= (n_seen || !n_any) ? '0 : n_max_stat;
            r_out_comp       <= n_seen ? '0 : n_max_comp;
            r_out_stat_valid <= !n_seen && n_any;
            r_out_measured   <= !n_seen;
        end
    end

    // a last word can only retire once the result register is free
    assign o_blocked            = i_valid && i_flags.last && r_out_valid && i_out_stall;
    assign o_out_valid          = r_out_valid;
    assign o_feasibility_eq     = r_out_eq;
    assign o_feasibility_ineq   = r_out_ineq;
    assign o_stationarity       = r_out_stat;
    assign o_complementarity    = r_out_comp;
    assign o_stationarity_valid = r_out_stat_valid;
    assign o_measured           = r_out_measured;

    a_unmeasured_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_measured |->
            r_out_eq == '0 && r_out_ineq == '0 && r_out_stat == '0 &&
            r_out_comp == '0 && !r_out_stat_valid)
        else $error("unmeasured result carries nonzero fields");

    a_stat_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_stat_valid |-> r_out_stat == '0)
        else $error("stationarity nonzero while flagged invalid");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_flags.last |=>
            r_max_eq == '0 && r_max_viol == '0 && r_max_stat == '0 &&
            r_max_comp == '0 && !r_any && !r_seen && r_out_valid)
        else $error("maxima not cleared after last word");

    a_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take || !i_flags.last |=>
            r_max_eq >= $past(r_max_eq) && r_max_viol >= $past(r_max_viol) &&
            r_max_stat >= $past(r_max_stat) && r_max_comp >= $past(r_max_comp))
        else $error("running maximum decreased without a last word");

endmodule

// ===== rtl/kkt_residual_norm_reducer.sv =====
// KKT residual infinity-norm reducer: takes one word (equality row,
// inequality row or coordinate) per cycle and keeps four saturating running
// maxima in unsigned Q(VALUE_WIDTH-1-FRACTION_BITS).FRACTION_BITS. A result
// word is presented once the last word of a problem has passed the input
// register, term formation, one VALUE_WIDTH x VALUE_WIDTH multiply and the max
// update into the result register. The multiplier stage sets the clock.
// Input stalls only when a last word reaches the accumulator while the
// previous result still waits to be taken; otherwise one word per cycle.
// Depends on krnr_pkg, krnr_prep, krnr_mul and krnr_accum.
module kkt_residual_norm_reducer #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_command,
    input  logic [VALUE_WIDTH-1:0]      i_row_residual,
    input  logic [VALUE_WIDTH-1:0]      i_row_multiplier,
    input  logic [VALUE_WIDTH-1:0]      i_x_value,
    input  logic [VALUE_WIDTH-1:0]      i_z_value,
    input  logic [VALUE_WIDTH-1:0]      i_grad_value,
    input  logic [VALUE_WIDTH-1:0]      i_lower_bound,
    input  logic [VALUE_WIDTH-1:0]      i_upper_bound,
    input  logic [1:0]                  i_bound_present,
    input  logic                        i_excluded,
    input  logic                        i_nonfinite,
    input  logic                        i_last,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [VALUE_WIDTH-2:0]      o_feasibility_eq,
    output logic [VALUE_WIDTH-2:0]      o_feasibility_ineq,
    output logic [VALUE_WIDTH-2:0]      o_stationarity,
    output logic [VALUE_WIDTH-2:0]      o_complementarity,
    output logic                        o_stationarity_valid,
    output logic                        o_measured
);
    localparam int W = VALUE_WIDTH;

    logic adv;
    logic blocked;

    // input register
    logic           r_valid;
    logic [1:0]     r_command;
    logic [W-1:0]   r_res, r_lam, r_x, r_z, r_g, r_lo, r_up;
    logic [1:0]     r_bp;
    logic           r_excl, r_nf, r_last;

    logic               p_valid;
    krnr_pkg::t_flags   p_flags;
    logic [W-2:0]       p_eq, p_v0, p_v1, p_stat;
    logic [W-1:0]       p_pa, p_pb;

    logic               m_valid;
    krnr_pkg::t_flags   m_flags;
    logic [W-2:0]       m_eq, m_viol, m_stat;
    logic [2*W-1:0]     m_prod;

    assign adv        = !blocked;
    assign o_in_stall = blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_in_valid;
        end
        if (adv && i_in_valid) begin
            r_command <= i_command;
            r_res     <= i_row_residual;
            r_lam     <= i_row_multiplier;
            r_x       <= i_x_value;
            r_z       <= i_z_value;
            r_g       <= i_grad_value;
            r_lo      <= i_lower_bound;
            r_up      <= i_upper_bound;
            r_bp      <= i_bound_present;
            r_excl    <= i_excluded;
            r_nf      <= i_nonfinite;
            r_last    <= i_last;
        end
    end

    krnr_prep #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_prep (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (adv),
        .i_valid          (r_valid),
        .i_command        (r_command),
        .i_row_residual   (r_res),
        .i_row_multiplier (r_lam),
        .i_x_value        (r_x),
        .i_z_value        (r_z),
        .i_grad_value     (r_g),
        .i_lower_bound    (r_lo),
        .i_upper_bound    (r_up),
        .i_bound_present  (r_bp),
        .i_excluded       (r_excl),
        .i_nonfinite      (r_nf),
        .i_last           (r_last),
        .o_valid          (p_valid),
        .o_flags          (p_flags),
        .o_eq             (p_eq),
        .o_v0             (p_v0),
        .o_v1             (p_v1),
        .o_stat           (p_stat),
        .o_pa             (p_pa),
        .o_pb             (p_pb)
    );

    krnr_mul #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (p_valid),
        .i_flags (p_flags),
        .i_eq    (p_eq),
        .i_v0    (p_v0),
        .i_v1    (p_v1),
        .i_stat  (p_stat),
        .i_pa    (p_pa),
        .i_pb    (p_pb),
        .o_valid (m_valid),
        .o_flags (m_flags),
        .o_eq    (m_eq),
        .o_viol  (m_viol),
        .o_stat  (m_stat),
        .o_prod  (m_prod)
    );

    krnr_accum #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_accum (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_adv                (adv),
        .i_valid              (m_valid),
        .i_flags              (m_flags),
        .i_eq                 (m_eq),
        .i_viol               (m_viol),
        .i_stat               (m_stat),
        .i_prod               (m_prod),
        .i_out_stall          (i_out_stall),
        .o_blocked            (blocked),
        .o_out_valid          (o_out_valid),
        .o_feasibility_eq     (o_feasibility_eq),
        .o_feasibility_ineq   (o_feasibility_ineq),
        .o_stationarity       (o_stationarity),
        .o_complementarity    (o_complementarity),
        .o_stationarity_valid (o_stationarity_valid),
        .o_measured           (o_measured)
    );

endmodule
